// ===== rtl/lmm_pkg.sv =====
// ----------------------------------------------------------------------------
// lmm_pkg
// Shared types and constants for the LED matrix layout mapper: register
// indexes, layout codes, divider stage state and pipeline sideband.
// ----------------------------------------------------------------------------
package lmm_pkg;

   // matrix size limits
   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;

   // field widths
   localparam int DIM_W   = 9;   // width / height register
   localparam int POS_W   = 8;   // column or row inside the matrix
   localparam int IDX_W   = 16;  // strip index and x field
   localparam int Y_W     = 8;   // y field
   localparam int MODE_W  = 4;   // layout_mode register
   localparam int TOT_W   = 17;  // width * height, up to 65536
   localparam int ADDR_W  = 2;   // csr register index
   localparam int DATA_W  = 9;   // csr write data

   // divider pipeline: quotient bits resolved per stage and stage count
   localparam int DIV_STEPS  = 4;
   localparam int DIV_STAGES = IDX_W / DIV_STEPS;

   // clamped dimension limits
   localparam logic [DIM_W-1:0] DIM_MAX_W = DIM_W'(MAX_WIDTH);
   localparam logic [DIM_W-1:0] DIM_MAX_H = DIM_W'(MAX_HEIGHT);

   // register indexes
   typedef enum logic [ADDR_W-1:0] {
      REG_LAYOUT_MODE   = 2'd0,
      REG_MATRIX_WIDTH  = 2'd1,
      REG_MATRIX_HEIGHT = 2'd2
   } csr_reg_type;

   // layout codes
   localparam logic [MODE_W-1:0] MODE_LINEAR    = 4'd0;
   localparam logic [MODE_W-1:0] MODE_VERT_LAST = 4'd4;
   localparam logic [MODE_W-1:0] MODE_LAST      = 4'd8;

   // command codes
   localparam logic CMD_TO_INDEX = 1'b0;
   localparam logic CMD_TO_COORD = 1'b1;

   // restoring divider state: num shifts dividend bits out, quotient bits in
   typedef struct packed {
      logic [DIM_W-1:0] dvs;
      logic [DIM_W-1:0] rem;
      logic [IDX_W-1:0] num;
   } div_type;

   // decoded item after the first compute stage
   typedef struct packed {
      logic             cmd;
      logic             bad_mode;
      logic             linear;
      logic             vertical;
      logic             xflip;
      logic             yflip;
      logic             coord_err;
      logic [POS_W-1:0] wm1;
      logic [POS_W-1:0] hm1;
      logic [TOT_W-1:0] total;
      logic [POS_W-1:0] major;
      logic [POS_W-1:0] minor;
      logic [DIM_W-1:0] mul;
      logic [IDX_W-1:0] x;
      logic [IDX_W-1:0] li;
   } dec_type;

   // sideband that travels beside the divider
   typedef struct packed {
      logic             cmd;
      logic             linear;
      logic             vertical;
      logic             xflip;
      logic             yflip;
      logic             err;
      logic [IDX_W-1:0] val;
      logic [POS_W-1:0] wm1;
      logic [POS_W-1:0] hm1;
   } side_type;

endpackage

// ===== rtl/lmm_div_stage.sv =====
// ----------------------------------------------------------------------------
// lmm_div_stage
// One registered slice of the restoring divider: resolves a few quotient
// bits of a 16-bit dividend by a 9-bit divisor and holds on stall.
// ----------------------------------------------------------------------------
module lmm_div_stage (
   input  logic              clock,
   input  logic              advance,
   input  lmm_pkg::div_type  prev_stage,
   output lmm_pkg::div_type  stage_ff
);

   lmm_pkg::div_type             stage_in;
   logic [lmm_pkg::DIM_W:0]      trial;

   // shift-compare-subtract steps
   always_comb begin
      stage_in = prev_stage;
      trial    = '0;
      for (int i = 0; i < lmm_pkg::DIV_STEPS; i++) begin
         trial        = {stage_in.rem, stage_in.num[lmm_pkg::IDX_W-1]};
         stage_in.num = {stage_in.num[lmm_pkg::IDX_W-2:0], 1'b0};
         if (trial >= {1'b0, stage_in.dvs}) begin
            stage_in.rem    = lmm_pkg::DIM_W'(trial - {1'b0, stage_in.dvs});
            stage_in.num[0] = 1'b1;
         end else begin
            stage_in.rem = trial[lmm_pkg::DIM_W-1:0];
         end
      end
   end

   // stage register
   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff <= stage_in;
      end
   end

endmodule

// ===== rtl/led_matrix_layout_mapper_core.sv =====
// ----------------------------------------------------------------------------
// led_matrix_layout_mapper_core
// Maps LED matrix coordinates to a strip position and back for linear and
// serpentine wirings, with a range flag for positions outside the matrix.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one lookup: command 0 turns (x, y) into a strip index,
//   command 1 turns a strip index into (x, y). rsp_* returns one result per
//   request, in order. Both channels transfer when valid and ready are high.
//   csr_* writes layout_mode, matrix_width and matrix_height; write only
//   while no request is in flight.
// Pipeline:
//   a request passes through the input register, the decode register,
//   four divider stages resolving four quotient bits each (the first one
//   beside the multiply), and the output register. One request is taken every cycle while the pipeline is not stalled.
// Reset:
//   synchronous; all pipeline valid bits clear, layout goes to linear and
//   both dimensions to 1.
// Stall:
//   when rsp_valid is high and rsp_ready low the whole pipeline holds and
//   req_ready drops; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module led_matrix_layout_mapper_core (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_command,
   input  logic [lmm_pkg::IDX_W-1:0]     req_x_coord,
   input  logic [lmm_pkg::Y_W-1:0]       req_y_coord,
   input  logic [lmm_pkg::IDX_W-1:0]     req_led_index,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [lmm_pkg::IDX_W-1:0]     rsp_index_out,
   output logic [lmm_pkg::IDX_W-1:0]     rsp_x_out,
   output logic [lmm_pkg::Y_W-1:0]       rsp_y_out,
   output logic                          rsp_range_error,
   // configuration port
   input  logic                          csr_wr_en,
   input  logic [lmm_pkg::ADDR_W-1:0]    csr_addr,
   input  logic [lmm_pkg::DATA_W-1:0]    csr_wr_data
);

   localparam int NS = lmm_pkg::DIV_STAGES;

   logic                          advance;

   // configuration registers
   logic [lmm_pkg::MODE_W-1:0]    mode_ff,   mode_in;
   logic [lmm_pkg::DIM_W-1:0]     width_ff,  width_in;
   logic [lmm_pkg::DIM_W-1:0]     height_ff, height_in;

   // input stage
   logic                          s0_vld_ff;
   logic                          s0_cmd_ff;
   logic [lmm_pkg::IDX_W-1:0]     s0_x_ff;
   logic [lmm_pkg::Y_W-1:0]       s0_y_ff;
   logic [lmm_pkg::IDX_W-1:0]     s0_li_ff;

   // decode stage
   logic                          s1_vld_ff;
   lmm_pkg::dec_type              dec_ff, dec_in;
   logic [lmm_pkg::DIM_W-1:0]     w_cl, h_cl;
   logic [2*lmm_pkg::DIM_W-1:0]   area;
   logic [lmm_pkg::MODE_W-1:0]    mode_m1;
   logic [lmm_pkg::POS_W-1:0]     col, row;

   // divider stages and sideband
   lmm_pkg::div_type              div_d [NS];
   lmm_pkg::div_type              div_q [NS];
   logic                          vld_ff [NS];
   lmm_pkg::side_type             side_ff [NS];
   lmm_pkg::side_type             side_in;
   logic [lmm_pkg::TOT_W-1:0]     mul_prod;
   logic [lmm_pkg::TOT_W-1:0]     idx_full;
   logic                          li_big, x_big;

   // output stage
   logic                          rsp_vld_ff;
   logic [lmm_pkg::IDX_W-1:0]     rsp_idx_ff, rsp_idx_in;
   logic [lmm_pkg::IDX_W-1:0]     rsp_x_ff,   rsp_x_in;
   logic [lmm_pkg::Y_W-1:0]       rsp_y_ff,   rsp_y_in;
   logic                          rsp_err_ff, rsp_err_in;
   lmm_pkg::side_type             last;
   logic [lmm_pkg::POS_W-1:0]     major, minor;
   logic [lmm_pkg::POS_W-1:0]     ox, oy;

   // pipeline moves when the output register is free or being drained
   assign advance   = !rsp_vld_ff || rsp_ready;
   assign req_ready = advance;

   // register writes
   always_comb begin
      mode_in   = mode_ff;
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_wr_en) begin
         unique case (csr_addr)
            lmm_pkg::REG_LAYOUT_MODE:   mode_in   = csr_wr_data[lmm_pkg::MODE_W-1:0];
            lmm_pkg::REG_MATRIX_WIDTH:  width_in  = csr_wr_data;
            lmm_pkg::REG_MATRIX_HEIGHT: height_in = csr_wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= lmm_pkg::MODE_LINEAR;
         width_ff  <= lmm_pkg::DIM_W'(1);
         height_ff <= lmm_pkg::DIM_W'(1);
      end else begin
         mode_ff   <= mode_in;
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else if (advance) begin
         s0_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_cmd_ff <= req_command;
         s0_x_ff   <= req_x_coord;
         s0_y_ff   <= req_y_coord;
         s0_li_ff  <= req_led_index;
      end
   end

   // decode: clamp dimensions, matrix area, mirror coordinates
   always_comb begin
      w_cl = width_ff;
      if (width_ff == '0) begin
         w_cl = lmm_pkg::DIM_W'(1);
      end else if (width_ff > lmm_pkg::DIM_MAX_W) begin
         w_cl = lmm_pkg::DIM_MAX_W;
      end
      h_cl = height_ff;
      if (height_ff == '0) begin
         h_cl = lmm_pkg::DIM_W'(1);
      end else if (height_ff > lmm_pkg::DIM_MAX_H) begin
         h_cl = lmm_pkg::DIM_MAX_H;
      end
      area    = w_cl * h_cl;
      mode_m1 = mode_ff - lmm_pkg::MODE_W'(1);

      dec_in.cmd       = s0_cmd_ff;
      dec_in.bad_mode  = mode_ff > lmm_pkg::MODE_LAST;
      dec_in.linear    = mode_ff == lmm_pkg::MODE_LINEAR;
      dec_in.vertical  = mode_ff <= lmm_pkg::MODE_VERT_LAST;
      dec_in.xflip     = mode_m1[0];
      dec_in.yflip     = mode_m1[1];
      dec_in.coord_err = ({{(lmm_pkg::IDX_W-lmm_pkg::DIM_W){1'b0}}, w_cl} <= s0_x_ff)
                      || ({1'b0, s0_y_ff} >= h_cl);
      dec_in.wm1       = lmm_pkg::POS_W'(w_cl - lmm_pkg::DIM_W'(1));
      dec_in.hm1       = lmm_pkg::POS_W'(h_cl - lmm_pkg::DIM_W'(1));
      dec_in.total     = area[lmm_pkg::TOT_W-1:0];
      dec_in.x         = s0_x_ff;
      dec_in.li        = s0_li_ff;

      if (dec_in.vertical) begin
         col = dec_in.xflip ? (dec_in.wm1 - s0_x_ff[lmm_pkg::POS_W-1:0])
                            : s0_x_ff[lmm_pkg::POS_W-1:0];
         row = ((col[0] == 1'b0) != dec_in.yflip) ? s0_y_ff : (dec_in.hm1 - s0_y_ff);
         dec_in.major = col;
         dec_in.minor = row;
         dec_in.mul   = h_cl;
      end else begin
         row = dec_in.yflip ? (dec_in.hm1 - s0_y_ff) : s0_y_ff;
         col = ((row[0] == 1'b0) != dec_in.xflip)
                  ? s0_x_ff[lmm_pkg::POS_W-1:0]
                  : (dec_in.wm1 - s0_x_ff[lmm_pkg::POS_W-1:0]);
         dec_in.major = row;
         dec_in.minor = col;
         dec_in.mul   = w_cl;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (advance) begin
         s1_vld_ff <= s0_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dec_ff <= dec_in;
      end
   end

   // strip index, bound checks and sideband for the divider stages
   always_comb begin
      mul_prod = dec_ff.major * dec_ff.mul;
      idx_full = mul_prod + {{(lmm_pkg::TOT_W-lmm_pkg::POS_W){1'b0}}, dec_ff.minor};
      li_big   = {1'b0, dec_ff.li} >= dec_ff.total;
      x_big    = {1'b0, dec_ff.x} >= dec_ff.total;

      side_in.cmd      = dec_ff.cmd;
      side_in.linear   = dec_ff.linear;
      side_in.vertical = dec_ff.vertical;
      side_in.xflip    = dec_ff.xflip;
      side_in.yflip    = dec_ff.yflip;
      side_in.wm1      = dec_ff.wm1;
      side_in.hm1      = dec_ff.hm1;
      if (dec_ff.linear) begin
         side_in.err = (dec_ff.cmd == lmm_pkg::CMD_TO_COORD) ? li_big : x_big;
         side_in.val = (dec_ff.cmd == lmm_pkg::CMD_TO_COORD) ? dec_ff.li : dec_ff.x;
      end else begin
         side_in.err = (dec_ff.cmd == lmm_pkg::CMD_TO_INDEX)
                          ? (dec_ff.coord_err || idx_full[lmm_pkg::TOT_W-1])
                          : li_big;
         side_in.val = idx_full[lmm_pkg::IDX_W-1:0];
      end
      side_in.err = side_in.err || dec_ff.bad_mode;
   end

   // divider inputs: the strip index divided by the run length
   always_comb begin
      div_d[0].dvs = dec_ff.mul;
      div_d[0].rem = '0;
      div_d[0].num = dec_ff.li;
      for (int k = 1; k < NS; k++) begin
         div_d[k] = div_q[k-1];
      end
   end

   for (genvar k = 0; k < NS; k++) begin : g_div
      lmm_div_stage u_div_stage (
         .clock      (clock),
         .advance    (advance),
         .prev_stage (div_d[k]),
         .stage_ff   (div_q[k])
      );
   end

   // valid bits and sideband beside the divider
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NS; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (advance) begin
         vld_ff[0] <= s1_vld_ff;
         for (int k = 1; k < NS; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff[0] <= side_in;
         for (int k = 1; k < NS; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // unmirror quotient and remainder, select result fields
   always_comb begin
      last  = side_ff[NS-1];
      major = div_q[NS-1].num[lmm_pkg::POS_W-1:0];
      minor = div_q[NS-1].rem[lmm_pkg::POS_W-1:0];
      if (last.vertical) begin
         ox = last.xflip ? (last.wm1 - major) : major;
         oy = ((major[0] == 1'b0) != last.yflip) ? minor : (last.hm1 - minor);
      end else begin
         ox = ((major[0] == 1'b0) != last.xflip) ? minor : (last.wm1 - minor);
         oy = last.yflip ? (last.hm1 - major) : major;
      end

      rsp_idx_in = '0;
      rsp_x_in   = '0;
      rsp_y_in   = '0;
      rsp_err_in = last.err;
      if (!last.err) begin
         if (last.cmd == lmm_pkg::CMD_TO_INDEX) begin
            rsp_idx_in = last.val;
         end else if (last.linear) begin
            rsp_x_in = last.val;
         end else begin
            rsp_x_in = {{(lmm_pkg::IDX_W-lmm_pkg::POS_W){1'b0}}, ox};
            rsp_y_in = oy;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         rsp_vld_ff <= vld_ff[NS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_idx_ff <= rsp_idx_in;
         rsp_x_ff   <= rsp_x_in;
         rsp_y_ff   <= rsp_y_in;
         rsp_err_ff <= rsp_err_in;
      end
   end

   assign rsp_valid       = rsp_vld_ff;
   assign rsp_index_out   = rsp_idx_ff;
   assign rsp_x_out       = rsp_x_ff;
   assign rsp_y_out       = rsp_y_ff;
   assign rsp_range_error = rsp_err_ff;

endmodule
